// ----- hw/rtl/ppuri_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppuri_pkg
// Shared types and constants of the picture unit register interface.
// ----------------------------------------------------------------------------
package ppuri_pkg;

    localparam int unsigned PALETTE_DEPTH = 32;
    localparam int unsigned OBJECT_DEPTH  = 256;
    localparam int unsigned PAL_AW        = 5;
    localparam int unsigned OBJ_AW        = 8;

    localparam logic [9:0] DOTS_PER_LINE   = 10'd341;
    localparam logic [8:0] VBLANK_LINE     = 9'd241;
    localparam logic [8:0] LINES_PER_FRAME = 9'd262;

    localparam logic [1:0] MIR_HORIZONTAL = 2'd0;
    localparam logic [1:0] MIR_VERTICAL   = 2'd1;

    typedef enum logic [3:0] {
        K_CTRL_WR     = 4'd0,
        K_MASK_WR     = 4'd1,
        K_STATUS_RD   = 4'd2,
        K_ADDR_WR     = 4'd3,
        K_DATA_WR     = 4'd4,
        K_DATA_RD     = 4'd5,
        K_OBJ_ADDR_WR = 4'd6,
        K_OBJ_DATA_WR = 4'd7,
        K_OBJ_DATA_RD = 4'd8,
        K_TICK        = 4'd9,
        K_PATTERN_LD  = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        RSEL_DIRECT,
        RSEL_PALETTE,
        RSEL_OBJECT,
        RSEL_NAMETABLE,
        RSEL_PATTERN
    } t_rsel;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  tick_dots;
        logic [12:0] pattern_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       write_error;
        logic       frame_event;
    } t_out_word;

    typedef struct packed {
        logic nt_we;
        logic nt_re;
        logic pal_we;
        logic pal_re;
        logic obj_we;
        logic obj_re;
        logic pat_we;
        logic pat_re;
    } t_mem_en;

endpackage
`default_nettype wire

// ----- hw/rtl/ppuri_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppuri_mem
// Nametable, palette, object and pattern memories with registered reads and
// a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module ppuri_mem #(
    parameter int unsigned NAMETABLE_DEPTH = 2048,
    parameter int unsigned PATTERN_DEPTH   = 8192,
    localparam int unsigned NT_AW = $clog2(NAMETABLE_DEPTH),
    localparam int unsigned PT_AW = $clog2(PATTERN_DEPTH)
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire ppuri_pkg::t_mem_en        i_en,
    input  wire [NT_AW-1:0]                i_nt_addr,
    input  wire [ppuri_pkg::PAL_AW-1:0]    i_pal_addr,
    input  wire [ppuri_pkg::OBJ_AW-1:0]    i_obj_addr,
    input  wire [PT_AW-1:0]                i_pat_addr,
    input  wire [7:0]                      i_wr_data,
    output logic [7:0]                     o_nt_q,
    output logic [7:0]                     o_pal_q,
    output logic [7:0]                     o_obj_q,
    output logic [7:0]                     o_pat_q,
    output logic                           o_clr_busy
);

    logic [7:0] nt_mem  [NAMETABLE_DEPTH];
    logic [7:0] pal_mem [ppuri_pkg::PALETTE_DEPTH];
    logic [7:0] obj_mem [ppuri_pkg::OBJECT_DEPTH];
    logic [7:0] pat_mem [PATTERN_DEPTH];

    logic             r_clr_busy, n_clr_busy;
    logic [NT_AW-1:0] r_clr_addr, n_clr_addr;

    logic                         nt_we, pal_we, obj_we;
    logic [NT_AW-1:0]             nt_wa;
    logic [ppuri_pkg::PAL_AW-1:0] pal_wa;
    logic [ppuri_pkg::OBJ_AW-1:0] obj_wa;
    logic [7:0]                   wd;

    // sweep zeros through every store that resets to zero
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + NT_AW'(1);
            if (r_clr_addr == NT_AW'(NAMETABLE_DEPTH - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign o_clr_busy = r_clr_busy;

    assign nt_we  = r_clr_busy | i_en.nt_we;
    assign pal_we = r_clr_busy | i_en.pal_we;
    assign obj_we = r_clr_busy | i_en.obj_we;
    assign nt_wa  = r_clr_busy ? r_clr_addr : i_nt_addr;
    assign pal_wa = r_clr_busy ? r_clr_addr[ppuri_pkg::PAL_AW-1:0] : i_pal_addr;
    assign obj_wa = r_clr_busy ? r_clr_addr[ppuri_pkg::OBJ_AW-1:0] : i_obj_addr;
    assign wd     = r_clr_busy ? 8'h00 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (nt_we) begin
            nt_mem[nt_wa] <= wd;
        end
        if (i_en.nt_re) begin
            o_nt_q <= nt_mem[i_nt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            pal_mem[pal_wa] <= wd;
        end
        if (i_en.pal_re) begin
            o_pal_q <= pal_mem[i_pal_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (obj_we) begin
            obj_mem[obj_wa] <= wd;
        end
        if (i_en.obj_re) begin
            o_obj_q <= obj_mem[i_obj_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.pat_we) begin
            pat_mem[i_pat_addr] <= i_wr_data;
        end
        if (i_en.pat_re) begin
            o_pat_q <= pat_mem[i_pat_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ppuri_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppuri_ctrl
// Register file, access decode, memory request generation and result register.
// ----------------------------------------------------------------------------
module ppuri_ctrl #(
    parameter int unsigned NAMETABLE_DEPTH = 2048,
    parameter int unsigned PATTERN_DEPTH   = 8192,
    localparam int unsigned NT_AW = $clog2(NAMETABLE_DEPTH),
    localparam int unsigned PT_AW = $clog2(PATTERN_DEPTH)
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire [1:0]                      i_cfg_wr_data,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire ppuri_pkg::t_in_word       i_in_word,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output ppuri_pkg::t_out_word           o_out_word,
    input  wire                            i_clr_busy,
    output ppuri_pkg::t_mem_en             o_mem_en,
    output logic [NT_AW-1:0]               o_nt_addr,
    output logic [ppuri_pkg::PAL_AW-1:0]   o_pal_addr,
    output logic [ppuri_pkg::OBJ_AW-1:0]   o_obj_addr,
    output logic [PT_AW-1:0]               o_pat_addr,
    output logic [7:0]                     o_wr_data,
    input  wire [7:0]                      i_nt_q,
    input  wire [7:0]                      i_pal_q,
    input  wire [7:0]                      i_obj_q,
    input  wire [7:0]                      i_pat_q
);

    localparam logic [12:0] NT_D  = 13'(NAMETABLE_DEPTH);
    localparam logic [15:0] PT_D1 = 16'(PATTERN_DEPTH);
    localparam logic [15:0] PT_D2 = 16'(PATTERN_DEPTH * 2);
    localparam logic [15:0] PT_D4 = 16'(PATTERN_DEPTH * 4);

    logic [1:0]  r_mirroring, n_mirroring;
    logic [7:0]  r_control, n_control;
    logic [7:0]  r_mask, n_mask;
    logic        r_vblank, n_vblank;
    logic [13:0] r_vaddr, n_vaddr;
    logic        r_latch, n_latch;
    logic [7:0]  r_buffer, n_buffer;
    logic [7:0]  r_obj_addr, n_obj_addr;
    logic [8:0]  r_dot, n_dot;
    logic [8:0]  r_line, n_line;
    logic        r_busy, n_busy;
    ppuri_pkg::t_rsel     r_rsel, n_rsel;
    logic [7:0]           r_rd, n_rd;
    logic                 r_err, n_err;
    logic                 r_ev, n_ev;
    logic                 r_out_valid, n_out_valid;
    ppuri_pkg::t_out_word r_out_word, n_out_word;

    logic        in_acc, fin;
    logic [13:0] vstep;
    logic [11:0] nt_fold;
    logic [12:0] nt_off;
    logic [12:0] pat_raw;
    logic [15:0] pat_t;
    logic [9:0]  dot_sum;
    logic [8:0]  line_inc;
    logic [7:0]  d;

    assign o_in_stall = r_busy | i_clr_busy;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign fin        = r_busy & (~r_out_valid | ~i_out_stall);
    assign d          = i_in_word.data_byte;
    assign vstep      = r_vaddr + (r_control[2] ? 14'd32 : 14'd1);

    // nametable folding by mirroring mode, then wrap to the store depth
    always_comb begin
        unique case (r_mirroring)
            ppuri_pkg::MIR_HORIZONTAL: nt_fold = {1'b0, r_vaddr[11], r_vaddr[9:0]};
            ppuri_pkg::MIR_VERTICAL:   nt_fold = {1'b0, r_vaddr[10], r_vaddr[9:0]};
            default:                   nt_fold = r_vaddr[11:0];
        endcase
        nt_off = {1'b0, nt_fold};
        if (nt_off >= NT_D) begin
            nt_off = nt_off - NT_D;
        end
    end

    // pattern index wrap: quotient is below 8, three restoring steps
    always_comb begin
        pat_raw = (i_in_word.kind == ppuri_pkg::K_PATTERN_LD) ?
                  i_in_word.pattern_index : r_vaddr[12:0];
        pat_t = {3'b000, pat_raw};
        if (pat_t >= PT_D4) begin
            pat_t = pat_t - PT_D4;
        end
        if (pat_t >= PT_D2) begin
            pat_t = pat_t - PT_D2;
        end
        if (pat_t >= PT_D1) begin
            pat_t = pat_t - PT_D1;
        end
    end

    assign o_nt_addr  = nt_off[NT_AW-1:0];
    assign o_pat_addr = pat_t[PT_AW-1:0];
    assign o_pal_addr = (r_vaddr[4] && (r_vaddr[1:0] == 2'b00)) ?
                        {1'b0, r_vaddr[3:0]} : r_vaddr[4:0];
    assign o_obj_addr = r_obj_addr;
    assign o_wr_data  = d;

    assign dot_sum  = {1'b0, r_dot} + {2'b00, i_in_word.tick_dots};
    assign line_inc = r_line + 9'd1;

    always_comb begin
        n_mirroring = i_cfg_wr_en ? i_cfg_wr_data : r_mirroring;
        n_control   = r_control;
        n_mask      = r_mask;
        n_vblank    = r_vblank;
        n_vaddr     = r_vaddr;
        n_latch     = r_latch;
        n_buffer    = r_buffer;
        n_obj_addr  = r_obj_addr;
        n_dot       = r_dot;
        n_line      = r_line;
        n_busy      = r_busy;
        n_rsel      = r_rsel;
        n_rd        = r_rd;
        n_err       = r_err;
        n_ev        = r_ev;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        o_mem_en    = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // finish: pick memory data, refill the read buffer, hand the word on
        if (fin) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
            n_out_word.write_error = r_err;
            n_out_word.frame_event = r_ev;
            unique case (r_rsel)
                ppuri_pkg::RSEL_PALETTE: n_out_word.read_byte = i_pal_q;
                ppuri_pkg::RSEL_OBJECT:  n_out_word.read_byte = i_obj_q;
                default:                 n_out_word.read_byte = r_rd;
            endcase
            unique case (r_rsel)
                ppuri_pkg::RSEL_NAMETABLE: n_buffer = i_nt_q;
                ppuri_pkg::RSEL_PATTERN:   n_buffer = i_pat_q;
                default:                   n_buffer = r_buffer;
            endcase
        end

        // accept: update registers, write memories, issue reads
        if (in_acc) begin
            n_busy = 1'b1;
            n_rsel = ppuri_pkg::RSEL_DIRECT;
            n_rd   = 8'h00;
            n_err  = 1'b0;
            n_ev   = 1'b0;
            unique case (i_in_word.kind)
                ppuri_pkg::K_CTRL_WR: n_control = d;
                ppuri_pkg::K_MASK_WR: n_mask = d;
                ppuri_pkg::K_STATUS_RD: begin
                    n_rd     = {r_vblank, 7'b0};
                    n_vblank = 1'b0;
                    n_latch  = 1'b0;
                end
                ppuri_pkg::K_ADDR_WR: begin
                    n_vaddr = r_latch ? {r_vaddr[13:8], d} : {d[5:0], r_vaddr[7:0]};
                    n_latch = ~r_latch;
                end
                ppuri_pkg::K_DATA_WR: begin
                    priority if (r_vaddr == 14'd0) begin
                        n_vaddr = r_vaddr;
                    end else if (r_vaddr[13:12] == 2'b10) begin
                        o_mem_en.nt_we = 1'b1;
                        n_vaddr = vstep;
                    end else if (r_vaddr[13:8] == 6'h3f) begin
                        o_mem_en.pal_we = 1'b1;
                        n_vaddr = vstep;
                    end else begin
                        n_err = r_mask[4];
                    end
                end
                ppuri_pkg::K_DATA_RD: begin
                    n_vaddr = vstep;
                    priority if (!r_vaddr[13]) begin
                        o_mem_en.pat_re = 1'b1;
                        n_rd   = r_buffer;
                        n_rsel = ppuri_pkg::RSEL_PATTERN;
                    end else if (r_vaddr[13:12] == 2'b10) begin
                        o_mem_en.nt_re = 1'b1;
                        n_rd   = r_buffer;
                        n_rsel = ppuri_pkg::RSEL_NAMETABLE;
                    end else if (r_vaddr[13:8] == 6'h3f) begin
                        o_mem_en.pal_re = 1'b1;
                        n_rsel = ppuri_pkg::RSEL_PALETTE;
                    end else begin
                        n_rsel = ppuri_pkg::RSEL_DIRECT;
                    end
                end
                ppuri_pkg::K_OBJ_ADDR_WR: n_obj_addr = d;
                ppuri_pkg::K_OBJ_DATA_WR: begin
                    o_mem_en.obj_we = 1'b1;
                    n_obj_addr = r_obj_addr + 8'd1;
                end
                ppuri_pkg::K_OBJ_DATA_RD: begin
                    o_mem_en.obj_re = 1'b1;
                    n_rsel = ppuri_pkg::RSEL_OBJECT;
                end
                ppuri_pkg::K_TICK: begin
                    n_dot = dot_sum[8:0];
                    if (dot_sum >= ppuri_pkg::DOTS_PER_LINE) begin
                        n_dot  = 9'(dot_sum - ppuri_pkg::DOTS_PER_LINE);
                        n_line = line_inc;
                        priority if (line_inc == ppuri_pkg::VBLANK_LINE) begin
                            n_vblank = 1'b1;
                            n_ev     = r_control[7];
                        end else if (line_inc >= ppuri_pkg::LINES_PER_FRAME) begin
                            n_line   = 9'd0;
                            n_vblank = 1'b0;
                            n_ev     = 1'b1;
                        end else begin
                            n_ev     = 1'b0;
                        end
                    end
                end
                ppuri_pkg::K_PATTERN_LD: o_mem_en.pat_we = 1'b1;
                default: n_rd = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirroring <= '0;
            r_control   <= '0;
            r_mask      <= '0;
            r_vblank    <= 1'b0;
            r_vaddr     <= '0;
            r_latch     <= 1'b0;
            r_buffer    <= '0;
            r_obj_addr  <= '0;
            r_dot       <= '0;
            r_line      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mirroring <= n_mirroring;
            r_control   <= n_control;
            r_mask      <= n_mask;
            r_vblank    <= n_vblank;
            r_vaddr     <= n_vaddr;
            r_latch     <= n_latch;
            r_buffer    <= n_buffer;
            r_obj_addr  <= n_obj_addr;
            r_dot       <= n_dot;
            r_line      <= n_line;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsel     <= n_rsel;
        r_rd       <= n_rd;
        r_err      <= n_err;
        r_ev       <= n_ev;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy)
        else $error("accepted word did not enter the busy stage");

    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result appeared without a word in flight");

    a_flags_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.write_error || r_out_word.frame_event))
        |-> (r_out_word.read_byte == 8'h00))
        else $error("flag word carries read data");

    a_timing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dot < 9'd341) && (r_line < ppuri_pkg::LINES_PER_FRAME))
        else $error("dot or scanline counter out of range");

endmodule
`default_nettype wire

// ----- hw/rtl/picture_unit_register_interface_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// picture_unit_register_interface_top
// Bus register side of a tile picture unit: control, mask, status, video
// address and data ports, object memory ports, pattern loads and dot ticks.
// ----------------------------------------------------------------------------
// Each accepted word has an accept step and a finish step: the accept edge
// updates the registers, performs any memory write and launches a memory
// read; the finish step takes the registered read data and loads the output
// register once it is empty or is being emptied by the output side. The
// result sits in that output register. The input side is stalled while a
// word is in flight and is free again as soon as its result moves into the
// output register. The memories (nametable, palette, object, pattern) have
// registered reads. After reset a zeroing sweep over the NAMETABLE_DEPTH
// nametable addresses clears nametable, palette and object memory; input is
// stalled for that time while configuration writes are still taken. The
// pattern store is not cleared: read it only where it was loaded. Mirroring:
// 0 horizontal, 1 vertical, 2 or 3 no folding; write it only while the block
// is idle.
// ----------------------------------------------------------------------------
module picture_unit_register_interface_top #(
    parameter int unsigned NAMETABLE_DEPTH = 2048,
    parameter int unsigned PATTERN_DEPTH   = 8192
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wr_en,
    input  wire [1:0]                i_cfg_wr_data,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire ppuri_pkg::t_in_word i_in_word,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output ppuri_pkg::t_out_word     o_out_word
);

    localparam int unsigned NT_AW = $clog2(NAMETABLE_DEPTH);
    localparam int unsigned PT_AW = $clog2(PATTERN_DEPTH);

    // memory request bundle from decode to the memory bank
    ppuri_pkg::t_mem_en           mem_en;
    logic [NT_AW-1:0]             nt_addr;
    logic [ppuri_pkg::PAL_AW-1:0] pal_addr;
    logic [ppuri_pkg::OBJ_AW-1:0] obj_addr;
    logic [PT_AW-1:0]             pat_addr;
    logic [7:0]                   wr_data;
    // registered read data back from the memory bank
    logic [7:0]                   nt_q, pal_q, obj_q, pat_q;
    // high while the post-reset sweep runs; hold input off
    logic                         clr_busy;

    ppuri_ctrl #(
        .NAMETABLE_DEPTH (NAMETABLE_DEPTH),
        .PATTERN_DEPTH   (PATTERN_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .i_clr_busy    (clr_busy),
        .o_mem_en      (mem_en),
        .o_nt_addr     (nt_addr),
        .o_pal_addr    (pal_addr),
        .o_obj_addr    (obj_addr),
        .o_pat_addr    (pat_addr),
        .o_wr_data     (wr_data),
        .i_nt_q        (nt_q),
        .i_pal_q       (pal_q),
        .i_obj_q       (obj_q),
        .i_pat_q       (pat_q)
    );

    ppuri_mem #(
        .NAMETABLE_DEPTH (NAMETABLE_DEPTH),
        .PATTERN_DEPTH   (PATTERN_DEPTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (mem_en),
        .i_nt_addr  (nt_addr),
        .i_pal_addr (pal_addr),
        .i_obj_addr (obj_addr),
        .i_pat_addr (pat_addr),
        .i_wr_data  (wr_data),
        .o_nt_q     (nt_q),
        .o_pal_q    (pal_q),
        .o_obj_q    (obj_q),
        .o_pat_q    (pat_q),
        .o_clr_busy (clr_busy)
    );

endmodule
`default_nettype wire
